@@ src/dbcf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the detection box containment filter.
// No dependencies; every other file of the block imports this package.
package dbcf_pkg;

  localparam int COORD_W     = 13;
  localparam int SIZE_W      = 12;
  localparam int OUT_COORD_W = 14;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int XSHIFT_W   = 10;
  localparam int OVERLAP_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_X_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP = 1'd1;

  localparam logic signed [XSHIFT_W-1:0] X_SHIFT_RST = -10'sd40;
  localparam logic [OVERLAP_W-1:0]       OVERLAP_RST = 4'd9;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } box_t;

  // One survivor on its way from the filter to the output stage.
  typedef struct packed {
    box_t box;
    logic last;
  } qent_t;

endpackage

@@ src/dbcf_front.sv @@
`timescale 1ns / 1ps
// Front end: collects a batch of boxes in the box store, runs the pairwise
// containment test and queues the survivors in input order. Uses dbcf_pkg.
module dbcf_front #(
  parameter int MAX_BOXES = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    batch_end,
  input  dbcf_pkg::box_t          box_in,
  input  logic [3:0]              overlap,
  output logic                    busy,
  output logic                    push,
  output dbcf_pkg::qent_t         push_data,
  input  logic                    full
);
  import dbcf_pkg::*;

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_FILTER,
    S_DRAIN,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       n_boxes;
  logic [IDX_W-1:0]       fi;
  logic [IDX_W-1:0]       fj;
  logic [IDX_W-1:0]       last_idx;
  logic [MAX_BOXES-1:0]   keep;
  logic                   acc;

  box_t                   mem [MAX_BOXES];
  box_t                   rd_a;
  box_t                   rd_b;

  logic                   accept;
  logic                   has_room;
  logic                   fi_last;
  logic                   fj_last;
  logic                   issue;
  logic                   row_hit;

  // Pair pipeline
  logic                   p1_v, p1_self, p1_rl;
  logic [IDX_W-1:0]       p1_i;
  logic                   p2_v, p2_self, p2_rl;
  logic [IDX_W-1:0]       p2_i;
  logic [SIZE_W-1:0]      p2_dx, p2_dy, p2_w, p2_h;
  logic                   p3_v, p3_self, p3_rl;
  logic [IDX_W-1:0]       p3_i;
  logic [23:0]            p3_inter, p3_own;
  logic                   p4_v, p4_hit, p4_rl;
  logic [IDX_W-1:0]       p4_i;

  logic signed [13:0]     a_l, a_r, b_l, b_r, x_lo, x_hi, x_diff;
  logic signed [13:0]     a_t, a_b, b_t, b_b, y_lo, y_hi, y_diff;
  logic [SIZE_W-1:0]      dx, dy;
  logic [23:0]            inter, own;
  logic [27:0]            lhs, rhs;
  logic                   hit;

  assign busy     = (state != S_LOAD);
  assign accept   = start && !busy;
  assign has_room = (count != CNT_W'(MAX_BOXES));
  assign fi_last  = ((CNT_W'(fi) + CNT_W'(1)) == n_boxes);
  assign fj_last  = ((CNT_W'(fj) + CNT_W'(1)) == n_boxes);
  assign issue    = (state == S_FILTER);
  assign row_hit  = acc | p4_hit;

  assign push           = (state == S_EMIT_WR) && keep[fi] && !full;
  assign push_data.box  = rd_a;
  assign push_data.last = (fi == last_idx);

  // Box store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      mem[count[IDX_W-1:0]] <= box_in;
    end
    rd_a <= mem[fi];
    rd_b <= mem[fj];
  end

  // Intersection extents; an empty overlap gives zero width or height.
  always_comb begin
    a_l    = {rd_a.x[COORD_W-1], rd_a.x};
    b_l    = {rd_b.x[COORD_W-1], rd_b.x};
    a_r    = a_l + $signed({2'b00, rd_a.w});
    b_r    = b_l + $signed({2'b00, rd_b.w});
    x_lo   = (a_l > b_l) ? a_l : b_l;
    x_hi   = (a_r < b_r) ? a_r : b_r;
    x_diff = x_hi - x_lo;
    dx     = (x_hi > x_lo) ? x_diff[SIZE_W-1:0] : '0;

    a_t    = {rd_a.y[COORD_W-1], rd_a.y};
    b_t    = {rd_b.y[COORD_W-1], rd_b.y};
    a_b    = a_t + $signed({2'b00, rd_a.h});
    b_b    = b_t + $signed({2'b00, rd_b.h});
    y_lo   = (a_t > b_t) ? a_t : b_t;
    y_hi   = (a_b < b_b) ? a_b : b_b;
    y_diff = y_hi - y_lo;
    dy     = (y_hi > y_lo) ? y_diff[SIZE_W-1:0] : '0;
  end

  assign inter = 24'(p2_dx) * 24'(p2_dy);
  assign own   = 24'(p2_w) * 24'(p2_h);

  // Contained when ten times the overlap reaches threshold times own area.
  assign lhs = (28'(p3_inter) << 3) + (28'(p3_inter) << 1);
  assign rhs = 28'(overlap) * 28'(p3_own);
  assign hit = !p3_self && (lhs >= rhs);

  always_ff @(posedge clk) begin
    p1_i     <= fi;
    p1_self  <= (fi == fj);
    p1_rl    <= fj_last;

    p2_i     <= p1_i;
    p2_self  <= p1_self;
    p2_rl    <= p1_rl;
    p2_dx    <= dx;
    p2_dy    <= dy;
    p2_w     <= rd_a.w;
    p2_h     <= rd_a.h;

    p3_i     <= p2_i;
    p3_self  <= p2_self;
    p3_rl    <= p2_rl;
    p3_inter <= inter;
    p3_own   <= own;

    p4_i     <= p3_i;
    p4_rl    <= p3_rl;
    p4_hit   <= hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      n_boxes  <= '0;
      fi       <= '0;
      fj       <= '0;
      last_idx <= '0;
      keep     <= '0;
      acc      <= 1'b0;
      p1_v     <= 1'b0;
      p2_v     <= 1'b0;
      p3_v     <= 1'b0;
      p4_v     <= 1'b0;
    end else begin
      p1_v <= issue;
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;

      // Rows leave the pipeline in order, so one flag gathers each row.
      if (p4_v) begin
        if (p4_rl) begin
          keep[p4_i] <= !row_hit;
          acc        <= 1'b0;
          if (!row_hit) begin
            last_idx <= p4_i;
          end
        end else begin
          acc <= row_hit;
        end
      end

      case (state)
        S_LOAD: begin
          if (accept) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
            end
            if (batch_end) begin
              n_boxes <= has_room ? count + CNT_W'(1) : count;
              fi      <= '0;
              fj      <= '0;
              state   <= S_FILTER;
            end
          end
        end
        S_FILTER: begin
          if (fj_last) begin
            fj <= '0;
            if (fi_last) begin
              fi    <= '0;
              state <= S_DRAIN;
            end else begin
              fi <= fi + IDX_W'(1);
            end
          end else begin
            fj <= fj + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (!p1_v && !p2_v && !p3_v && !p4_v) begin
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (!keep[fi] || !full) begin
            if (fi_last) begin
              fi    <= '0;
              count <= '0;
              state <= S_LOAD;
            end else begin
              fi    <= fi + IDX_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

@@ src/dbcf_queue.sv @@
`timescale 1ns / 1ps
// Short survivor queue between the filter and the output stage.
// Uses dbcf_pkg for the entry type.
module dbcf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dbcf_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output dbcf_pkg::qent_t pop_data
);
  import dbcf_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  qent_t            q [DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W:0]   cnt;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt == (PTR_W + 1)'(DEPTH));
  assign empty    = (cnt == '0);
  assign pop_data = q[rp];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + PTR_W'(1);
      end
      if (do_pop) begin
        rp <= rp + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + (PTR_W + 1)'(1);
        2'b01:   cnt <= cnt - (PTR_W + 1)'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

@@ src/dbcf_back.sv @@
`timescale 1ns / 1ps
// Back end: shrinks each queued survivor and presents it for one cycle.
// Three pipeline stages; uses dbcf_pkg.
module dbcf_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   avail,
  input  dbcf_pkg::qent_t        entry,
  input  logic signed [9:0]      x_shift,
  output logic                   pop,
  output logic                   result_strobe,
  output logic signed [13:0]     out_x,
  output logic signed [13:0]     out_y,
  output logic [11:0]            out_w,
  output logic [11:0]            out_h,
  output logic                   run_end
);
  import dbcf_pkg::*;

  // Reciprocals scaled by 2^20; the error stays far below one part in the
  // range of the numerators, so the shifted product is the exact quotient.
  localparam logic [16:0] K10  = 17'd104858;
  localparam logic [13:0] K100 = 14'd10486;
  localparam logic signed [14:0] SAT_HI = 15'sd8191;
  localparam logic signed [14:0] SAT_LO = -15'sd8192;
  localparam logic [12:0] SIZE_MAX = 13'd4095;

  function automatic logic signed [13:0] sat14(input logic signed [14:0] v);
    logic signed [13:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[13:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[13:0];
    end else begin
      r = v[13:0];
    end
    return r;
  endfunction

  logic [13:0]        nw3;
  logic [14:0]        nh8, nh7;
  logic [30:0]        pw;
  logic [31:0]        ph8;
  logic [28:0]        ph7;
  logic [11:0]        xh;
  logic [14:0]        x_sum;

  logic               s1_v, s1_last;
  logic [14:0]        s1_x;
  logic [12:0]        s1_y;
  logic [13:0]        s1_nw3;
  logic [14:0]        s1_nh8, s1_nh7;
  logic [30:0]        s1_pw;
  logic [31:0]        s1_ph8;
  logic [28:0]        s1_ph7;

  logic [10:0]        qw;
  logic [11:0]        qh8;
  logic [8:0]         qh7;
  logic [13:0]        rw_full;
  logic [14:0]        rh8_full, rh7_full;

  logic               s2_v, s2_last;
  logic [14:0]        s2_x;
  logic [12:0]        s2_y;
  logic [10:0]        s2_qw;
  logic [11:0]        s2_qh8;
  logic [8:0]         s2_qh7;
  logic [3:0]         s2_rw, s2_rh8;
  logic [6:0]         s2_rh7;

  logic               upw, uph8, uph7;
  logic [12:0]        ow, oh;
  logic [14:0]        oy;

  assign pop = avail;

  // Stage 1: numerators and reciprocal products; w/2 rounds half to even.
  always_comb begin
    nw3   = 14'({entry.box.w, 1'b0}) + 14'(entry.box.w);
    nh8   = {entry.box.h, 3'b000};
    nh7   = 15'({entry.box.h, 3'b000}) - 15'(entry.box.h);
    pw    = 31'(nw3) * 31'(K10);
    ph8   = 32'(nh8) * 32'(K10);
    ph7   = 29'(nh7) * 29'(K100);
    xh    = {1'b0, entry.box.w[11:1]} + 12'(entry.box.w[0] & entry.box.w[1]);
    x_sum = 15'({{2{entry.box.x[COORD_W-1]}}, entry.box.x}) + 15'(xh)
            + {{5{x_shift[9]}}, x_shift};
  end

  // Stage 2: quotients and remainders.
  always_comb begin
    qw       = s1_pw[30:20];
    qh8      = s1_ph8[31:20];
    qh7      = s1_ph7[28:20];
    rw_full  = s1_nw3 - 14'(qw) * 14'd10;
    rh8_full = s1_nh8 - 15'(qh8) * 15'd10;
    rh7_full = s1_nh7 - 15'(qh7) * 15'd100;
  end

  // Stage 3: round half to even, offset and saturate.
  always_comb begin
    upw  = (s2_rw > 4'd5) || ((s2_rw == 4'd5) && s2_qw[0]);
    uph8 = (s2_rh8 > 4'd5) || ((s2_rh8 == 4'd5) && s2_qh8[0]);
    uph7 = (s2_rh7 > 7'd50) || ((s2_rh7 == 7'd50) && s2_qh7[0]);
    ow   = 13'(s2_qw) + 13'(upw);
    oh   = 13'(s2_qh8) + 13'(uph8);
    oy   = 15'({{2{s2_y[12]}}, s2_y}) + 15'(s2_qh7) + 15'(uph7);
  end

  always_ff @(posedge clk) begin
    s1_last <= entry.last;
    s1_x    <= x_sum;
    s1_y    <= entry.box.y;
    s1_nw3  <= nw3;
    s1_nh8  <= nh8;
    s1_nh7  <= nh7;
    s1_pw   <= pw;
    s1_ph8  <= ph8;
    s1_ph7  <= ph7;

    s2_last <= s1_last;
    s2_x    <= s1_x;
    s2_y    <= s1_y;
    s2_qw   <= qw;
    s2_qh8  <= qh8;
    s2_qh7  <= qh7;
    s2_rw   <= rw_full[3:0];
    s2_rh8  <= rh8_full[3:0];
    s2_rh7  <= rh7_full[6:0];

    out_x   <= sat14($signed(s2_x));
    out_y   <= sat14($signed(oy));
    out_w   <= (ow > SIZE_MAX) ? SIZE_MAX[11:0] : ow[11:0];
    out_h   <= (oh > SIZE_MAX) ? SIZE_MAX[11:0] : oh[11:0];
    run_end <= s2_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      s1_v          <= avail;
      s2_v          <= s1_v;
      result_strobe <= s2_v;
    end
  end

endmodule

@@ src/detection_box_containment_filter_top.sv @@
`timescale 1ns / 1ps
// Top level of the detection box containment filter: configuration
// registers and the front end, survivor queue and back end. Uses dbcf_pkg.
//
// Boxes are loaded one per cycle while busy is low; a box with batch_end
// high closes the batch. For a batch of n stored boxes the block then stays
// busy while the n*n pairs go through the pairwise containment pipeline
// one per cycle, limited by the two read ports of the box store, and while
// the boxes are read back in order and the survivors queued, waiting while
// the queue is full. Each survivor then passes the back-end stages
// and appears on the result ports for exactly one cycle with result_strobe
// high; the receiver cannot stall and must take every beat.
// A new batch may be loaded while the last survivors are still coming out.
// Once the store holds MAX_BOXES boxes, further boxes are dropped.
module detection_box_containment_filter_top #(
  parameter int MAX_BOXES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [dbcf_pkg::COORD_W-1:0] box_x,
  input  logic signed [dbcf_pkg::COORD_W-1:0] box_y,
  input  logic [dbcf_pkg::SIZE_W-1:0]         box_w,
  input  logic [dbcf_pkg::SIZE_W-1:0]         box_h,
  input  logic                                batch_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dbcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbcf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                result_strobe,
  output logic signed [dbcf_pkg::OUT_COORD_W-1:0] out_x,
  output logic signed [dbcf_pkg::OUT_COORD_W-1:0] out_y,
  output logic [dbcf_pkg::SIZE_W-1:0]         out_w,
  output logic [dbcf_pkg::SIZE_W-1:0]         out_h,
  output logic                                run_end
);
  import dbcf_pkg::*;

  logic signed [XSHIFT_W-1:0] x_shift;
  logic [OVERLAP_W-1:0]       overlap;
  box_t                       box_in;
  logic                       push;
  qent_t                      push_data;
  logic                       full;
  logic                       pop;
  logic                       empty;
  qent_t                      pop_data;

  assign cfg_ready = 1'b1;

  assign box_in.x = box_x;
  assign box_in.y = box_y;
  assign box_in.w = box_w;
  assign box_in.h = box_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_shift <= X_SHIFT_RST;
      overlap <= OVERLAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_SHIFT: x_shift <= $signed(cfg_data[XSHIFT_W-1:0]);
        REG_OVERLAP: overlap <= cfg_data[OVERLAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dbcf_front #(
    .MAX_BOXES (MAX_BOXES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .batch_end (batch_end),
    .box_in    (box_in),
    .overlap   (overlap),
    .busy      (busy),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  dbcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_data)
  );

  dbcf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .avail         (!empty),
    .entry         (pop_data),
    .x_shift       (x_shift),
    .pop           (pop),
    .result_strobe (result_strobe),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_w         (out_w),
    .out_h         (out_h),
    .run_end       (run_end)
  );

endmodule
